FILE: hdl/bprq_pkg.sv
// shared constants, codes and memory entry types of the bitmap priority run queue
`timescale 1ns / 1ps

package bprq_pkg;

   // sizes follow from the field widths
   localparam int TASK_W  = 6;
   localparam int LEVEL_W = 5;
   localparam int TASKS   = 1 << TASK_W;
   localparam int LEVELS  = 1 << LEVEL_W;

   // operation codes
   localparam logic [1:0] OP_PUT = 2'd0;
   localparam logic [1:0] OP_GET = 2'd1;
   localparam logic [1:0] OP_DEL = 2'd2;

   // status codes
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_MISUSE = 2'd2;

   // per level list ends
   typedef struct packed {
      logic [TASK_W-1:0] head;
      logic [TASK_W-1:0] tail;
   } lvl_entry_type;

   // per task links and the level it was put at
   typedef struct packed {
      logic [TASK_W-1:0]  next;
      logic [TASK_W-1:0]  prev;
      logic [LEVEL_W-1:0] level;
   } tsk_entry_type;

   // lowest set bit of the level map, zero when none is set
   function automatic logic [LEVEL_W-1:0] lowest_level(input logic [LEVELS-1:0] map);
      logic [LEVEL_W-1:0] lv;
      lv = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (map[i]) begin
            lv = LEVEL_W'(i);
         end
      end
      return lv;
   endfunction

endpackage

FILE: hdl/bitmap_priority_run_queue.sv
// top level of the bitmap priority run queue: sequencer, level and task memories
`timescale 1ns / 1ps

// Run queue of task ids with one FIFO list per priority level.
// req channel: one beat carries an operation (put, get, delete), a task id and
// a priority level. rsp channel: one beat per request with the task taken or
// echoed, its level, a status (done, empty, misuse) and whether any level is
// still non-empty afterwards.
// Lists live in two synchronous memories with registered read data: a level
// memory with head and tail per level, and a task memory with next, prev and
// level per task. The non-empty level map and the per task queued marks are
// flip-flops, cleared by reset; the memories need no clearing.
// One request is worked on at a time. Misuse and empty go straight to the
// response; a put writes the level entry, then the new task's links; a get
// reads the lowest non-empty level, then its head's links, and unlinks the
// head (a get always takes a list head); a delete reads both memories, checks
// the level and unlinks, with a second link write from the middle of a list.
// The steps follow the read latency of the two memories and the single write
// port of the task memory, one link update per cycle. On a receiver stall the
// response holds in its output register and no request is taken until loaded.

module bitmap_priority_run_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_operation,
   input  logic [bprq_pkg::TASK_W-1:0]   req_task_id,
   input  logic [bprq_pkg::LEVEL_W-1:0]  req_priority_req,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bprq_pkg::TASK_W-1:0]   rsp_task_id_out,
   output logic [bprq_pkg::LEVEL_W-1:0]  rsp_priority_out,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_any_ready
);

   typedef enum logic [2:0] {
      S_IDLE, S_PUT1, S_PUT2, S_DCHK, S_GLVL, S_UNLINK, S_UNLINK2, S_RESP
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]                   op_ff, op_in;
   logic [bprq_pkg::TASK_W-1:0]  tid_ff, tid_in;
   logic [bprq_pkg::LEVEL_W-1:0] pri_ff, pri_in;
   logic [1:0]                   status_ff, status_in;
   logic [bprq_pkg::LEVELS-1:0]  map_ff, map_in;
   logic [bprq_pkg::TASKS-1:0]   queued_ff, queued_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bprq_pkg::TASK_W-1:0]  rsp_tid_ff, rsp_tid_in;
   logic [bprq_pkg::LEVEL_W-1:0] rsp_pri_ff, rsp_pri_in;
   logic [1:0]                   rsp_status_ff, rsp_status_in;
   logic                         rsp_any_ff, rsp_any_in;

   // level memory ports
   bprq_pkg::lvl_entry_type      lvl_mem [bprq_pkg::LEVELS];
   bprq_pkg::lvl_entry_type      lvl_rd_ff;
   logic                         lm_re;
   logic [bprq_pkg::LEVEL_W-1:0] lm_raddr;
   logic                         lm_we;
   logic [bprq_pkg::LEVEL_W-1:0] lm_waddr;
   bprq_pkg::lvl_entry_type      lm_wdata;

   // task memory ports, with a write enable per field
   bprq_pkg::tsk_entry_type      tsk_mem [bprq_pkg::TASKS];
   bprq_pkg::tsk_entry_type      tsk_rd_ff;
   logic                         tm_re;
   logic [bprq_pkg::TASK_W-1:0]  tm_raddr;
   logic                         tm_we_next, tm_we_prev, tm_we_lvl;
   logic [bprq_pkg::TASK_W-1:0]  tm_waddr;
   bprq_pkg::tsk_entry_type      tm_wdata;

   logic is_head, is_tail;

   assign is_head = (lvl_rd_ff.head == tid_ff);
   assign is_tail = (lvl_rd_ff.tail == tid_ff);

   // level memory
   always_ff @(posedge clock) begin
      if (lm_we) begin
         lvl_mem[lm_waddr] <= lm_wdata;
      end
      if (lm_re) begin
         lvl_rd_ff <= lvl_mem[lm_raddr];
      end
   end

   // task memory
   always_ff @(posedge clock) begin
      if (tm_we_next) begin
         tsk_mem[tm_waddr].next <= tm_wdata.next;
      end
      if (tm_we_prev) begin
         tsk_mem[tm_waddr].prev <= tm_wdata.prev;
      end
      if (tm_we_lvl) begin
         tsk_mem[tm_waddr].level <= tm_wdata.level;
      end
      if (tm_re) begin
         tsk_rd_ff <= tsk_mem[tm_raddr];
      end
   end

   // sequencer next state and memory controls
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      tid_in        = tid_ff;
      pri_in        = pri_ff;
      status_in     = status_ff;
      map_in        = map_ff;
      queued_in     = queued_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_tid_in    = rsp_tid_ff;
      rsp_pri_in    = rsp_pri_ff;
      rsp_status_in = rsp_status_ff;
      rsp_any_in    = rsp_any_ff;
      req_ready     = 1'b0;
      lm_re         = 1'b0;
      lm_raddr      = pri_ff;
      lm_we         = 1'b0;
      lm_waddr      = pri_ff;
      lm_wdata      = lvl_rd_ff;
      tm_re         = 1'b0;
      tm_raddr      = tid_ff;
      tm_we_next    = 1'b0;
      tm_we_prev    = 1'b0;
      tm_we_lvl     = 1'b0;
      tm_waddr      = tid_ff;
      tm_wdata      = tsk_rd_ff;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_operation;
               tid_in    = req_task_id;
               pri_in    = req_priority_req;
               status_in = bprq_pkg::ST_MISUSE;
               state_in  = S_RESP;
               case (req_operation)
                  bprq_pkg::OP_PUT: begin
                     if (!queued_ff[req_task_id]) begin
                        lm_re    = 1'b1;
                        lm_raddr = req_priority_req;
                        state_in = S_PUT1;
                     end
                  end
                  bprq_pkg::OP_GET: begin
                     if (map_ff == '0) begin
                        status_in = bprq_pkg::ST_EMPTY;
                        pri_in    = '0;
                     end else begin
                        pri_in   = bprq_pkg::lowest_level(map_ff);
                        lm_re    = 1'b1;
                        lm_raddr = bprq_pkg::lowest_level(map_ff);
                        state_in = S_GLVL;
                     end
                  end
                  bprq_pkg::OP_DEL: begin
                     if (queued_ff[req_task_id]) begin
                        lm_re    = 1'b1;
                        lm_raddr = req_priority_req;
                        tm_re    = 1'b1;
                        tm_raddr = req_task_id;
                        state_in = S_DCHK;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         // link behind the old tail and move the tail
         S_PUT1: begin
            if (map_ff[pri_ff]) begin
               tm_we_next    = 1'b1;
               tm_waddr      = lvl_rd_ff.tail;
               tm_wdata.next = tid_ff;
               lm_wdata.head = lvl_rd_ff.head;
            end else begin
               lm_wdata.head = tid_ff;
            end
            lm_we             = 1'b1;
            lm_wdata.tail     = tid_ff;
            map_in[pri_ff]    = 1'b1;
            queued_in[tid_ff] = 1'b1;
            state_in          = S_PUT2;
         end

         // back link and level of the new task; prev of a lone head is never read
         S_PUT2: begin
            tm_we_prev     = 1'b1;
            tm_we_lvl      = 1'b1;
            tm_waddr       = tid_ff;
            tm_wdata.prev  = lvl_rd_ff.tail;
            tm_wdata.level = pri_ff;
            status_in      = bprq_pkg::ST_DONE;
            state_in       = S_RESP;
         end

         // head of the chosen level known: fetch its links
         S_GLVL: begin
            tid_in   = lvl_rd_ff.head;
            tm_re    = 1'b1;
            tm_raddr = lvl_rd_ff.head;
            state_in = S_UNLINK;
         end

         // unlink, for delete only when the level matches
         S_DCHK, S_UNLINK: begin
            if (state_ff == S_DCHK && tsk_rd_ff.level != pri_ff) begin
               status_in = bprq_pkg::ST_MISUSE;
               state_in  = S_RESP;
            end else begin
               queued_in[tid_ff] = 1'b0;
               status_in         = bprq_pkg::ST_DONE;
               state_in          = S_RESP;
               if (is_head && is_tail) begin
                  map_in[pri_ff] = 1'b0;
               end else if (is_head) begin
                  lm_we         = 1'b1;
                  lm_wdata.head = tsk_rd_ff.next;
               end else if (is_tail) begin
                  lm_we         = 1'b1;
                  lm_wdata.tail = tsk_rd_ff.prev;
               end else begin
                  tm_we_next    = 1'b1;
                  tm_waddr      = tsk_rd_ff.prev;
                  tm_wdata.next = tsk_rd_ff.next;
                  state_in      = S_UNLINK2;
               end
            end
         end

         // second half of a middle unlink
         S_UNLINK2: begin
            tm_we_prev    = 1'b1;
            tm_waddr      = tsk_rd_ff.next;
            tm_wdata.prev = tsk_rd_ff.prev;
            state_in      = S_RESP;
         end

         // load the response once the output register is free
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_tid_in    = tid_ff;
               rsp_pri_in    = pri_ff;
               rsp_status_in = status_ff;
               rsp_any_in    = (map_ff != '0);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, level map, queued marks and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         map_ff       <= '0;
         queued_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         map_ff       <= map_in;
         queued_ff    <= queued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      tid_ff        <= tid_in;
      pri_ff        <= pri_in;
      status_ff     <= status_in;
      rsp_tid_ff    <= rsp_tid_in;
      rsp_pri_ff    <= rsp_pri_in;
      rsp_status_ff <= rsp_status_in;
      rsp_any_ff    <= rsp_any_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_task_id_out  = rsp_tid_ff;
   assign rsp_priority_out = rsp_pri_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_any_ready    = rsp_any_ff;

   // a request beat is followed by work before the next beat is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while the previous one is in progress");

   // an empty get reports no ready level
   a_empty_not_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bprq_pkg::ST_EMPTY) |-> !rsp_any_ready)
      else $error("empty status with a non-empty queue");

   // no level is marked non-empty without a queued task
   a_map_needs_tasks: assert property (@(posedge clock) disable iff (reset)
      ($countones(queued_ff) == 0) |-> (map_ff == '0))
      else $error("level map set while no task is queued");

   // while idle, no more levels are non-empty than tasks are queued
   a_map_le_tasks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(map_ff) <= $countones(queued_ff)))
      else $error("more non-empty levels than queued tasks");

   // the get level state is entered only for a get
   a_get_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GLVL) |-> (op_ff == bprq_pkg::OP_GET))
      else $error("get sequence entered for another operation");

endmodule

FILE: tb/bitmap_priority_run_queue_tb.sv
// self-checking testbench of the bitmap priority run queue: directed table, random ops
`timescale 1ns / 1ps

module bitmap_priority_run_queue_tb;
   import bprq_pkg::*;

   // operation code the block does not define
   localparam logic [1:0] OP_BAD = 2'd3;
   localparam int RANDOM_PER_PHASE = 188;
   localparam int DRAIN_CYCLES = 20;

   // one response beat, field by field
   typedef struct packed {
      logic [TASK_W-1:0]  tid;
      logic [LEVEL_W-1:0] lvl;
      logic [1:0]         status;
      logic               any_ready;
   } rsp_beat_t;

   // one request beat, with an optional hand-written response
   typedef struct packed {
      logic [1:0]         op;
      logic [TASK_W-1:0]  tid;
      logic [LEVEL_W-1:0] lvl;
      logic               typed;
      rsp_beat_t          want;
   } req_beat_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_operation = OP_PUT;
   logic [TASK_W-1:0]   req_task_id = '0;
   logic [LEVEL_W-1:0]  req_priority_req = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [TASK_W-1:0]   rsp_task_id_out;
   logic [LEVEL_W-1:0]  rsp_priority_out;
   logic [1:0]          rsp_status;
   logic                rsp_any_ready;

   // shadow copy of the run queue
   logic [LEVELS-1:0]   sh_map;
   logic [TASK_W-1:0]   sh_head [LEVELS];
   logic [TASK_W-1:0]   sh_tail [LEVELS];
   logic [TASK_W-1:0]   sh_next [TASKS];
   logic [TASK_W-1:0]   sh_prev [TASKS];
   logic [LEVEL_W-1:0]  sh_level [TASKS];
   logic                sh_queued [TASKS];

   rsp_beat_t           expected_rsp_q [$];
   logic [LEVEL_W-1:0]  hot_lvl [4];
   int                  send_gap_pct = 0;
   int                  recv_stall_pct = 0;
   int                  requests_sent = 0;
   int                  responses_checked = 0;
   int                  error_count = 0;
   int                  status_seen [4] = '{0, 0, 0, 0};

   bitmap_priority_run_queue dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_task_id      (req_task_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_task_id_out  (rsp_task_id_out),
      .rsp_priority_out (rsp_priority_out),
      .rsp_status       (rsp_status),
      .rsp_any_ready    (rsp_any_ready)
   );

   // clock
   always #5 clock = ~clock;

   // run limit
   initial begin
      #2_000_000;
      $display("timeout with %0d responses outstanding", expected_rsp_q.size());
      $display("Regression FAIL");
      $finish;
   end

   // take a task out of its level list in the shadow
   function automatic void shadow_unlink(input logic [TASK_W-1:0] t,
                                         input logic [LEVEL_W-1:0] p);
      logic                at_head;
      logic                at_tail;
      logic [TASK_W-1:0]   nx;
      logic [TASK_W-1:0]   pv;
      at_head = (sh_head[p] == t);
      at_tail = (sh_tail[p] == t);
      nx = sh_next[t];
      pv = sh_prev[t];
      if (at_head && at_tail) begin
         sh_map[p] = 1'b0;
      end else if (at_head) begin
         sh_head[p] = nx;
      end else if (at_tail) begin
         sh_tail[p] = pv;
      end else begin
         sh_next[pv] = nx;
         sh_prev[nx] = pv;
      end
      sh_queued[t] = 1'b0;
   endfunction

   // apply one request to the shadow and return the response it should give;
   // the field widths cover the whole task and level range, so no range misuse
   function automatic rsp_beat_t run_queue_step(input logic [1:0] op,
                                                input logic [TASK_W-1:0] t,
                                                input logic [LEVEL_W-1:0] p);
      rsp_beat_t           r;
      logic [LEVEL_W-1:0]  lv;
      logic [TASK_W-1:0]   h;
      logic                found;
      r.tid = t;
      r.lvl = p;
      r.status = ST_MISUSE;
      case (op)
         OP_PUT: begin
            if (!sh_queued[t]) begin
               if (sh_map[p]) begin
                  sh_next[sh_tail[p]] = t;
                  sh_prev[t] = sh_tail[p];
               end else begin
                  sh_head[p] = t;
               end
               sh_tail[p] = t;
               sh_map[p] = 1'b1;
               sh_queued[t] = 1'b1;
               sh_level[t] = p;
               r.status = ST_DONE;
            end
         end
         OP_GET: begin
            if (sh_map == '0) begin
               r.status = ST_EMPTY;
               r.lvl = '0;
            end else begin
               // lowest non-empty level is served first
               lv = '0;
               found = 1'b0;
               for (int i = 0; i < LEVELS; i++) begin
                  if (!found && sh_map[i]) begin
                     lv = LEVEL_W'(i);
                     found = 1'b1;
                  end
               end
               h = sh_head[lv];
               shadow_unlink(h, lv);
               r.tid = h;
               r.lvl = lv;
               r.status = ST_DONE;
            end
         end
         OP_DEL: begin
            if (sh_queued[t] && sh_level[t] == p) begin
               shadow_unlink(t, p);
               r.status = ST_DONE;
            end
         end
         default: begin
         end
      endcase
      r.any_ready = |sh_map;
      return r;
   endfunction

   // build a table row
   function automatic req_beat_t row(input logic [1:0] op, input int tid, input int lvl,
                                     input logic typed = 1'b0, input rsp_beat_t want = '0);
      req_beat_t b;
      b.op = op;
      b.tid = TASK_W'(tid);
      b.lvl = LEVEL_W'(lvl);
      b.typed = typed;
      b.want = want;
      return b;
   endfunction

   // random request: mostly valid puts and deletes, with gets, misuse and bad codes
   function automatic req_beat_t random_request();
      req_beat_t           b;
      int                  roll;
      int                  tries;
      logic [TASK_W-1:0]   t;
      b = '0;
      roll = $urandom_range(99);
      b.tid = TASK_W'($urandom_range(TASKS - 1));
      b.lvl = LEVEL_W'($urandom_range(LEVELS - 1));
      if (roll < 48) begin
         b.op = OP_PUT;
         // favour tasks not yet queued, and a few busy levels to grow long lists
         if (roll < 44) begin
            t = b.tid;
            tries = 0;
            while (sh_queued[t] && tries < TASKS) begin
               t = TASK_W'($urandom_range(TASKS - 1));
               tries++;
            end
            b.tid = t;
         end
         if ($urandom_range(99) < 60) begin
            b.lvl = hot_lvl[$urandom_range(3)];
         end
      end else if (roll < 70) begin
         b.op = OP_GET;
      end else if (roll < 95) begin
         b.op = OP_DEL;
         // mostly a queued task at its own level
         if (roll < 90) begin
            t = b.tid;
            tries = 0;
            while (!sh_queued[t] && tries < TASKS) begin
               t = TASK_W'($urandom_range(TASKS - 1));
               tries++;
            end
            b.tid = t;
            if (sh_queued[t]) begin
               b.lvl = sh_level[t];
            end
         end
      end else begin
         b.op = OP_BAD;
      end
      return b;
   endfunction

   // drive one request beat and record its expected response on acceptance
   task automatic send_request(input req_beat_t b);
      rsp_beat_t predicted;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= b.op;
      req_task_id <= b.tid;
      req_priority_req <= b.lvl;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predicted = run_queue_step(b.op, b.tid, b.lvl);
      expected_rsp_q.push_back(b.typed ? b.want : predicted);
      requests_sent++;
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // response checker
   always @(posedge clock) begin
      rsp_beat_t got;
      rsp_beat_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_task_id_out, rsp_priority_out, rsp_status, rsp_any_ready};
         status_seen[got.status]++;
         responses_checked++;
         if (expected_rsp_q.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("%0t: response beat with no request pending: task %0d level %0d",
                        $realtime, got.tid, got.lvl);
            end
         end else begin
            want = expected_rsp_q.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t: mismatch task %0d/%0d level %0d/%0d status %0d/%0d any %0d/%0d",
                           $realtime, want.tid, got.tid, want.lvl, got.lvl,
                           want.status, got.status, want.any_ready, got.any_ready);
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      req_beat_t directed_vec [24];
      req_beat_t b;
      int        waited;
      sh_map = '0;
      for (int i = 0; i < LEVELS; i++) begin
         sh_head[i] = '0;
         sh_tail[i] = '0;
      end
      for (int i = 0; i < TASKS; i++) begin
         sh_next[i] = '0;
         sh_prev[i] = '0;
         sh_level[i] = '0;
         sh_queued[i] = 1'b0;
      end
      directed_vec = '{
         row(OP_GET, 21, 9, 1'b1, {6'd21, 5'd0, ST_EMPTY, 1'b0}),   // get when empty
         row(OP_DEL, 5, 3, 1'b1, {6'd5, 5'd3, ST_MISUSE, 1'b0}),    // delete not queued
         row(OP_BAD, 42, 17, 1'b1, {6'd42, 5'd17, ST_MISUSE, 1'b0}),
         row(OP_PUT, 63, 31, 1'b1, {6'd63, 5'd31, ST_DONE, 1'b1}),
         row(OP_PUT, 63, 31, 1'b1, {6'd63, 5'd31, ST_MISUSE, 1'b1}), // put twice
         row(OP_PUT, 0, 0, 1'b1, {6'd0, 5'd0, ST_DONE, 1'b1}),
         row(OP_GET, 63, 31, 1'b1, {6'd0, 5'd0, ST_DONE, 1'b1}),     // level 0 first
         row(OP_DEL, 63, 0, 1'b1, {6'd63, 5'd0, ST_MISUSE, 1'b1}),   // wrong level
         row(OP_PUT, 10, 5),
         row(OP_PUT, 11, 5),
         row(OP_PUT, 12, 5),
         row(OP_PUT, 13, 5),
         row(OP_DEL, 11, 5),                                         // middle of list
         row(OP_DEL, 10, 5),                                         // head
         row(OP_DEL, 13, 5),                                         // tail
         row(OP_GET, 0, 0),
         row(OP_GET, 0, 0),
         row(OP_GET, 63, 31, 1'b1, {6'd63, 5'd0, ST_EMPTY, 1'b0}),
         row(OP_PUT, 1, 31),
         row(OP_PUT, 2, 31),
         row(OP_DEL, 2, 31),
         row(OP_GET, 0, 0),
         row(OP_BAD, 63, 31, 1'b1, {6'd63, 5'd31, ST_MISUSE, 1'b0}),
         row(OP_DEL, 0, 0, 1'b1, {6'd0, 5'd0, ST_MISUSE, 1'b0})
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // idling phases: none, sender gaps, receiver stalls, both
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 66; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 66; end
            default: begin send_gap_pct = 24; recv_stall_pct = 24; end
         endcase
         for (int k = 0; k < 4; k++) begin
            hot_lvl[k] = LEVEL_W'($urandom_range(LEVELS - 1));
         end
         if (ph == 0) begin
            foreach (directed_vec[i]) begin
               send_request(directed_vec[i]);
            end
         end
         repeat (RANDOM_PER_PHASE) begin
            b = random_request();
            send_request(b);
         end
      end
      req_valid <= 1'b0;

      // drain, then watch for stray beats
      waited = 0;
      while (expected_rsp_q.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsp_q.size() != 0) begin
         error_count += expected_rsp_q.size();
         $display("%0d responses never arrived", expected_rsp_q.size());
      end

      $display("%0d requests sent, %0d responses checked over four idling phases",
               requests_sent, responses_checked);
      $display("statuses seen: %0d done, %0d empty, %0d misuse; %0d errors",
               status_seen[ST_DONE], status_seen[ST_EMPTY], status_seen[ST_MISUSE],
               error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
